// ===== rtl/core/exor_pkg.sv =====
// Package for the EXIF orientation extractor: widths, tag constants and the
// microcode program that drives the parse datapath. No dependencies.
package exor_pkg;

    localparam int unsigned STORE_BYTES_DEFAULT = 65536;

    localparam int unsigned PTR_W = 17;
    localparam int unsigned CMP_W = 18;
    localparam int unsigned PC_W  = 5;

    localparam logic [7:0]  MAGIC_E   = 8'h45;
    localparam logic [7:0]  MAGIC_X   = 8'h78;
    localparam logic [7:0]  MAGIC_I   = 8'h69;
    localparam logic [7:0]  MAGIC_F   = 8'h66;
    localparam logic [7:0]  MAGIC_PAD = 8'h00;
    localparam logic [7:0]  ORDER_II  = 8'h49;
    localparam logic [7:0]  ORDER_MM  = 8'h4D;
    localparam logic [15:0] TIFF_MARK = 16'h002A;
    localparam logic [15:0] TAG_ORIENTATION = 16'h0112;

    localparam int unsigned MIN_LEN     = 20;
    localparam int unsigned IFD_TAIL    = 14;
    localparam int unsigned ENTRY_BYTES = 12;
    localparam int unsigned TIFF_BASE   = 6;

    localparam logic [3:0] ORIENT_DEFAULT = 4'd1;
    localparam logic [7:0] ORIENT_MAX     = 8'd8;

    localparam logic [PC_W-1:0] STEP_PARSE = 5'd0;
    localparam logic [PC_W-1:0] STEP_ENTRY = 5'd18;
    localparam logic [PC_W-1:0] STEP_EMIT  = 5'd23;
    localparam int unsigned     PROG_LEN   = 24;

    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_CHKLEN = 4'd1,
        OP_MAGIC  = 4'd2,
        OP_HOLD   = 4'd3,
        OP_ORDER  = 4'd4,
        OP_CHK2A  = 4'd5,
        OP_WORD   = 4'd6,
        OP_OFFSET = 4'd7,
        OP_CHKP   = 4'd8,
        OP_COUNT  = 4'd9,
        OP_ENTRY  = 4'd10,
        OP_TAG    = 4'd11,
        OP_VALUE  = 4'd12,
        OP_EMIT   = 4'd13
    } op_t;

    typedef struct packed {
        op_t             op;
        logic            use_ptr;
        logic [3:0]      off;
        logic [7:0]      imm;
        logic            loop_on_miss;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Each step issues one store read and acts on the byte read by the step before.
    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t cw;
        cw = '{op: OP_EMIT, use_ptr: 1'b0, off: 4'd0, imm: 8'h00,
               loop_on_miss: 1'b0, target: STEP_ENTRY};
        unique case (pc)
            5'd0:  begin cw.op = OP_CHKLEN; cw.off = 4'd0; end
            5'd1:  begin cw.op = OP_MAGIC; cw.off = 4'd1; cw.imm = MAGIC_E; end
            5'd2:  begin cw.op = OP_MAGIC; cw.off = 4'd2; cw.imm = MAGIC_X; end
            5'd3:  begin cw.op = OP_MAGIC; cw.off = 4'd3; cw.imm = MAGIC_I; end
            5'd4:  begin cw.op = OP_MAGIC; cw.off = 4'd4; cw.imm = MAGIC_F; end
            5'd5:  begin cw.op = OP_MAGIC; cw.off = 4'd5; cw.imm = MAGIC_PAD; end
            5'd6:  begin cw.op = OP_MAGIC; cw.off = 4'd6; cw.imm = MAGIC_PAD; end
            5'd7:  begin cw.op = OP_HOLD;   cw.off = 4'd7; end
            5'd8:  begin cw.op = OP_ORDER;  cw.off = 4'd8; end
            5'd9:  begin cw.op = OP_HOLD;   cw.off = 4'd9; end
            5'd10: begin cw.op = OP_CHK2A;  cw.off = 4'd10; end
            5'd11: begin cw.op = OP_HOLD;   cw.off = 4'd11; end
            5'd12: begin cw.op = OP_WORD;   cw.off = 4'd12; end
            5'd13: begin cw.op = OP_HOLD;   cw.off = 4'd13; end
            5'd14: begin cw.op = OP_OFFSET; end
            5'd15: begin cw.op = OP_CHKP;   cw.use_ptr = 1'b1; cw.off = 4'd0; end
            5'd16: begin cw.op = OP_HOLD;   cw.use_ptr = 1'b1; cw.off = 4'd1; end
            5'd17: begin cw.op = OP_COUNT; end
            5'd18: begin cw.op = OP_ENTRY;  cw.use_ptr = 1'b1; cw.off = 4'd0; end
            5'd19: begin cw.op = OP_HOLD;   cw.use_ptr = 1'b1; cw.off = 4'd1; end
            5'd20:
            begin
                cw.op = OP_TAG;
                cw.use_ptr = 1'b1;
                cw.off = 4'd8;
                cw.loop_on_miss = 1'b1;
                cw.target = STEP_ENTRY;
            end
            5'd21: begin cw.op = OP_HOLD;   cw.use_ptr = 1'b1; cw.off = 4'd9; end
            5'd22: begin cw.op = OP_VALUE; end
            default: begin cw.op = OP_EMIT; end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/core/exif_orientation_extractor.sv =====
// EXIF orientation extractor: takes one payload byte per cycle while idle; after the
// last byte a 24-step microcode program walks the stored payload, jumping to the
// emit step on any failed check; the emit step waits while out_stall holds a shown
// result. Input is stalled for that walk; the store has a single read port.
// Reset clears control state; the store is not cleared. Depends on exor_pkg.
module exif_orientation_extractor #(
    parameter int unsigned STORE_BYTES = exor_pkg::STORE_BYTES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] orientation
);

    localparam int unsigned AW    = $clog2(STORE_BYTES);
    localparam int unsigned LEN_W = $clog2(STORE_BYTES + 1);
    localparam int unsigned PTR_W = exor_pkg::PTR_W;
    localparam int unsigned CMP_W = exor_pkg::CMP_W;
    localparam int unsigned PC_W  = exor_pkg::PC_W;

    logic [7:0] store_mem [STORE_BYTES];
    logic [7:0] rdata_reg;

    logic                busy_reg, busy_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                big_reg, big_next;
    logic [7:0]          bprev_reg, bprev_next;
    logic [15:0]         w_reg, w_next;
    logic [PTR_W-1:0]    p_reg, p_next;
    logic [15:0]         n_reg, n_next;
    logic [3:0]          res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          orient_reg, orient_next;

    exor_pkg::ucode_t    cw;
    logic                wr_en;
    logic [AW-1:0]       wr_idx;
    logic [PTR_W-1:0]    rd_addr;
    logic [AW-1:0]       rd_idx;
    logic [15:0]         word16;
    logic [15:0]         hi_half;
    logic [15:0]         lo_half;
    logic [7:0]          value;
    logic                fail;
    logic                slot_free;

    assign cw       = exor_pkg::ucode(pc_reg);
    assign in_stall = busy_reg;
    assign wr_en    = in_valid && !busy_reg && (len_reg < LEN_W'(STORE_BYTES));
    assign wr_idx   = len_reg[AW-1:0];
    assign rd_addr  = (cw.use_ptr ? p_reg : '0) + PTR_W'(cw.off);
    assign rd_idx   = rd_addr[AW-1:0];
    assign word16   = big_reg ? {bprev_reg, rdata_reg} : {rdata_reg, bprev_reg};
    assign hi_half  = big_reg ? w_reg : word16;
    assign lo_half  = big_reg ? word16 : w_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_idx] <= data_byte;
        end
        rdata_reg <= store_mem[rd_idx];
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        len_next       = len_reg;
        big_next       = big_reg;
        bprev_next     = bprev_reg;
        w_next         = w_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        orient_next    = orient_reg;
        fail           = 1'b0;
        value          = 8'h00;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (in_valid && !busy_reg)
        begin
            if (wr_en)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            if (last_byte)
            begin
                busy_next = 1'b1;
                pc_next   = exor_pkg::STEP_PARSE;
                res_next  = exor_pkg::ORIENT_DEFAULT;
            end
        end

        if (busy_reg)
        begin
            pc_next = pc_reg + PC_W'(1);
            unique case (cw.op)
                exor_pkg::OP_NOP:
                begin
                end
                exor_pkg::OP_CHKLEN:
                begin
                    fail = CMP_W'(len_reg) < CMP_W'(exor_pkg::MIN_LEN);
                end
                exor_pkg::OP_MAGIC:
                begin
                    fail = rdata_reg != cw.imm;
                end
                exor_pkg::OP_HOLD:
                begin
                    bprev_next = rdata_reg;
                end
                exor_pkg::OP_ORDER:
                begin
                    if (bprev_reg == exor_pkg::ORDER_II && rdata_reg == exor_pkg::ORDER_II)
                    begin
                        big_next = 1'b0;
                    end
                    else if (bprev_reg == exor_pkg::ORDER_MM
                             && rdata_reg == exor_pkg::ORDER_MM)
                    begin
                        big_next = 1'b1;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                exor_pkg::OP_CHK2A:
                begin
                    fail = word16 != exor_pkg::TIFF_MARK;
                end
                exor_pkg::OP_WORD:
                begin
                    w_next = word16;
                end
                exor_pkg::OP_OFFSET:
                begin
                    fail   = hi_half != 16'h0000;
                    p_next = PTR_W'(lo_half) + PTR_W'(exor_pkg::TIFF_BASE);
                end
                exor_pkg::OP_CHKP:
                begin
                    fail = (CMP_W'(p_reg) + CMP_W'(exor_pkg::IFD_TAIL)) > CMP_W'(len_reg);
                end
                exor_pkg::OP_COUNT:
                begin
                    n_next = word16;
                    p_next = p_reg + PTR_W'(2);
                end
                exor_pkg::OP_ENTRY:
                begin
                    if (n_reg == 16'h0000
                        || (CMP_W'(p_reg) + CMP_W'(exor_pkg::ENTRY_BYTES)) > CMP_W'(len_reg))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        n_next = n_reg - 16'd1;
                    end
                end
                exor_pkg::OP_TAG:
                begin
                    if (cw.loop_on_miss && word16 != exor_pkg::TAG_ORIENTATION)
                    begin
                        p_next  = p_reg + PTR_W'(exor_pkg::ENTRY_BYTES);
                        pc_next = cw.target;
                    end
                end
                exor_pkg::OP_VALUE:
                begin
                    if (big_reg && bprev_reg == 8'h00)
                    begin
                        value = rdata_reg;
                    end
                    else if (rdata_reg == 8'h00)
                    begin
                        value = bprev_reg;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                    if (!fail && value != 8'h00 && value <= exor_pkg::ORIENT_MAX)
                    begin
                        res_next = value[3:0];
                    end
                end
                exor_pkg::OP_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        orient_next    = res_reg;
                        busy_next      = 1'b0;
                        len_next       = '0;
                    end
                    else
                    begin
                        pc_next = pc_reg;
                    end
                end
                default:
                begin
                    fail = 1'b1;
                end
            endcase
            if (fail)
            begin
                pc_next = exor_pkg::STEP_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= exor_pkg::STEP_PARSE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        big_reg    <= big_next;
        bprev_reg  <= bprev_next;
        w_reg      <= w_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        res_reg    <= res_next;
        orient_reg <= orient_next;
    end

    assign out_valid   = out_valid_reg;
    assign orientation = orient_reg;

`ifndef SYNTHESIS
    // A new result appears only from the emit step of a running parse.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && pc_reg == exor_pkg::STEP_EMIT))
        else $error("result raised outside the emit step");

    // A shown result is always a legal orientation.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (orient_reg != 4'd0 && orient_reg <= 4'd8))
        else $error("orientation out of range");

    // The step counter stays inside the program while parsing.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg < PC_W'(exor_pkg::PROG_LEN)))
        else $error("step counter left the program");

    // The stored length never passes the store size.
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(STORE_BYTES))
        else $error("payload length beyond store size");
`endif

endmodule
